### hw/rtl/wbc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbc_pkg
// Shared types and constants for the word break checker: store geometry,
// command codes, controller states and the structs passed between modules.
// ----------------------------------------------------------------------------
package wbc_pkg;

	localparam int DICT_WORDS   = 64;
	localparam int MAX_WORD_LEN = 32;
	localparam int CHAR_W       = 8;

	// word slot address, word counter (holds DICT_WORDS itself)
	localparam int ADDR_W = (DICT_WORDS > 1) ? $clog2(DICT_WORDS) : 1;
	localparam int CNT_W  = $clog2(DICT_WORDS + 1);
	// character position inside a slot, and word length (holds MAX_WORD_LEN)
	localparam int POS_W  = (MAX_WORD_LEN > 1) ? $clog2(MAX_WORD_LEN) : 1;
	localparam int LEN_W  = $clog2(MAX_WORD_LEN + 1);

	typedef logic [CHAR_W-1:0] char_t;
	typedef logic [MAX_WORD_LEN-1:0][CHAR_W-1:0] row_t;

	typedef enum logic [1:0] {
		CMD_CLEAR = 2'd0,
		CMD_DICT  = 2'd1,
		CMD_TEXT  = 2'd2
	} cmd_e;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_SCAN,
		ST_DRAIN,
		ST_FINISH
	} state_t;

	// window cell control
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

	// word store write request
	typedef struct packed {
		logic              char_en;
		logic              len_en;
		logic [ADDR_W-1:0] row;
		logic [POS_W-1:0]  col;
		char_t             ch_val;
		logic [LEN_W-1:0]  len;
	} store_wr_t;

endpackage

### hw/rtl/wbc_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbc_cell
// One text window cell: holds one text character, passes it to the next
// cell on every text shift, and compares it with the word character that
// lines up with it for the word currently read from the store.
// ----------------------------------------------------------------------------
module wbc_cell (
	input  logic                        clk,
	input  logic                        arst_n,
	input  wbc_pkg::cell_ctrl_t         ctrl,
	input  wbc_pkg::char_t              char_in,
	input  logic [wbc_pkg::POS_W-1:0]   pos,
	input  wbc_pkg::row_t               word_row,
	input  logic [wbc_pkg::LEN_W-1:0]   word_len,
	output wbc_pkg::char_t              char_out,
	output logic                        eq
);
	import wbc_pkg::*;

	char_t            char_q;
	logic [LEN_W-1:0] sel_idx;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			char_q <= '0;
		end else if (ctrl.clear) begin
			char_q <= '0;
		end else if (ctrl.shift) begin
			char_q <= char_in;
		end
	end

	assign char_out = char_q;

	// cell k holds the character k back, which must equal word char len-1-k
	always_comb begin
		sel_idx = word_len - LEN_W'(pos) - LEN_W'(1);
		if (LEN_W'(pos) < word_len) begin
			eq = (word_row[sel_idx[POS_W-1:0]] == char_q);
		end else begin
			eq = 1'b1;
		end
	end

endmodule

### hw/rtl/wbc_word_store.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbc_word_store
// Dictionary memory: one row of MAX_WORD_LEN characters per word slot plus
// a length memory. Byte writes while loading, one registered row read per
// cycle while scanning.
// ----------------------------------------------------------------------------
module wbc_word_store (
	input  logic                         clk,
	input  wbc_pkg::store_wr_t           wr,
	input  logic                         rd_en,
	input  logic [wbc_pkg::ADDR_W-1:0]   rd_addr,
	output wbc_pkg::row_t                rd_row,
	output logic [wbc_pkg::LEN_W-1:0]    rd_len
);
	import wbc_pkg::*;

	row_t             chars_mem [DICT_WORDS];
	logic [LEN_W-1:0] len_mem   [DICT_WORDS];

	always_ff @(posedge clk) begin
		if (wr.char_en) begin
			chars_mem[wr.row][wr.col] <= wr.ch_val;
		end
		if (wr.len_en) begin
			len_mem[wr.row] <= wr.len;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			rd_row <= chars_mem[rd_addr];
			rd_len <= len_mem[rd_addr];
		end
	end

endmodule

### hw/rtl/word_break_checker_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// word_break_checker_top
// Word break checker: loads dictionary words into a word store, then decides
// for each streamed text whether it splits wholly into dictionary words.
//
//   channel | handshake           | payload
//   --------+---------------------+-----------------------
//   in      | in_valid / in_ready | cmd, ch, last
//   out     | out_valid/out_ready | breakable, dict_error
//
// Clear and dictionary characters are taken in idle and keep the input open.
// A text character passes through accept, a read of each stored word through
// the store's single read port, a drain step and a finish; with an empty store
// it skips scan and drain.
// Reset takes effect at once; the store needs no clearing pass.
// A result waits in the output register while the next items are taken; a
// later final text character holds in finish until that register is free.
// ----------------------------------------------------------------------------
module word_break_checker_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  cmd,
	input  logic [7:0]  ch,
	input  logic        last,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        breakable,
	output logic        dict_error
);
	import wbc_pkg::*;

	state_t state_q, state_d;

	logic [CNT_W-1:0]      word_count_q;
	logic [LEN_W-1:0]      load_len_q;
	logic                  too_long_q;
	logic                  err_q;
	logic [MAX_WORD_LEN:0] hist_q;
	logic [ADDR_W-1:0]     idx_q;
	logic                  last_q;
	logic                  hit_q;
	logic                  rd_valid_s1;
	logic                  out_valid_q;
	logic                  breakable_q;
	logic                  dict_error_q;

	logic                  accept;
	logic                  text_acc;
	logic                  dict_acc;
	logic                  rd_en;
	logic                  fin_go;
	logic                  room;
	logic                  fits;
	logic                  drop;
	logic [LEN_W-1:0]      len_new;
	store_wr_t             wr;
	cell_ctrl_t            cell_ctrl;
	row_t                  rd_row;
	logic [LEN_W-1:0]      rd_len;
	logic [LEN_W-1:0]      hist_idx;
	logic                  match;

	char_t                 win_chars [MAX_WORD_LEN];
	logic [MAX_WORD_LEN-1:0] eq_vec;

	assign accept   = in_valid & in_ready;
	assign text_acc = accept & (cmd_e'(cmd) == CMD_TEXT);
	assign dict_acc = accept & (cmd_e'(cmd) == CMD_DICT);
	assign fin_go   = !last_q || !out_valid_q || out_ready;

	// controller
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		in_ready  = 1'b0;
		rd_en     = 1'b0;
		cell_ctrl = '0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (text_acc) begin
					cell_ctrl.shift = 1'b1;
					state_d = (word_count_q == '0) ? ST_FINISH : ST_SCAN;
				end
			end
			ST_SCAN: begin
				rd_en = 1'b1;
				if (CNT_W'(idx_q) + CNT_W'(1) == word_count_q) begin
					state_d = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				state_d = ST_FINISH;
			end
			ST_FINISH: begin
				if (fin_go) begin
					cell_ctrl.clear = last_q;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// dictionary loading
	always_comb begin
		room       = word_count_q < CNT_W'(DICT_WORDS);
		fits       = load_len_q < LEN_W'(MAX_WORD_LEN);
		len_new    = load_len_q + LEN_W'(room && fits);
		drop       = !room || too_long_q || !fits;
		wr.char_en = dict_acc && room && fits;
		wr.len_en  = dict_acc && last && !drop;
		wr.row     = word_count_q[ADDR_W-1:0];
		wr.col     = load_len_q[POS_W-1:0];
		wr.ch_val  = ch;
		wr.len     = len_new;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_count_q <= '0;
			load_len_q   <= '0;
			too_long_q   <= 1'b0;
			err_q        <= 1'b0;
		end else if (accept) begin
			case (cmd_e'(cmd))
				CMD_CLEAR: begin
					word_count_q <= '0;
					load_len_q   <= '0;
					too_long_q   <= 1'b0;
					err_q        <= 1'b0;
				end
				CMD_DICT: begin
					if (last) begin
						if (drop) begin
							err_q <= 1'b1;
						end else begin
							word_count_q <= word_count_q + CNT_W'(1);
						end
						load_len_q <= '0;
						too_long_q <= 1'b0;
					end else begin
						load_len_q <= len_new;
						if (room && !fits) begin
							too_long_q <= 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// word store
	wbc_word_store u_store (
		.clk      (clk),
		.wr       (wr),
		.rd_en    (rd_en),
		.rd_addr  (idx_q),
		.rd_row   (rd_row),
		.rd_len   (rd_len)
	);

	// text window chain, newest character in cell 0
	for (genvar k = 0; k < MAX_WORD_LEN; k++) begin : g_cell
		char_t cell_in;
		if (k == 0) begin : g_head
			assign cell_in = ch;
		end else begin : g_link
			assign cell_in = win_chars[k-1];
		end
		wbc_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctrl     (cell_ctrl),
			.char_in  (cell_in),
			.pos      (POS_W'(k)),
			.word_row (rd_row),
			.word_len (rd_len),
			.char_out (win_chars[k]),
			.eq       (eq_vec[k])
		);
	end

	// word of length len matches if its start prefix is breakable
	assign hist_idx = rd_len - LEN_W'(1);
	assign match    = (&eq_vec) && (rd_len != '0) && hist_q[hist_idx];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			last_q      <= 1'b0;
			hit_q       <= 1'b0;
			rd_valid_s1 <= 1'b0;
			hist_q      <= (MAX_WORD_LEN+1)'(1);
		end else begin
			rd_valid_s1 <= rd_en;
			if (text_acc) begin
				idx_q  <= '0;
				last_q <= last;
				hit_q  <= 1'b0;
			end else begin
				if (rd_en) begin
					idx_q <= idx_q + ADDR_W'(1);
				end
				if (rd_valid_s1 && match) begin
					hit_q <= 1'b1;
				end
			end
			if (state_q == ST_FINISH && fin_go) begin
				if (last_q) begin
					hist_q <= (MAX_WORD_LEN+1)'(1);
				end else begin
					hist_q <= {hist_q[MAX_WORD_LEN-1:0], hit_q};
				end
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == ST_FINISH && last_q && fin_go) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_FINISH && last_q && fin_go) begin
			breakable_q  <= hit_q;
			dict_error_q <= err_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign breakable  = breakable_q;
	assign dict_error = dict_error_q;

endmodule

### hw/rtl/wbc_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// wbc_checker
// Port-level checks for the word break checker, bound to the top level.
// ----------------------------------------------------------------------------
module wbc_checker (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	input  logic       in_ready,
	input  logic [1:0] cmd,
	input  logic       last,
	input  logic       out_valid,
	input  logic       out_ready,
	input  logic       breakable,
	input  logic       dict_error
);
	import wbc_pkg::*;

	logic in_acc;
	assign in_acc = in_valid && in_ready;

	// a held result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(breakable) && $stable(dict_error))
		else $error("result changed while stalled");

	// a text transaction always moves the controller out of idle, so input closes
	a_text_busy: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && cmd == CMD_TEXT |=> !in_ready)
		else $error("input open right after a text character");

	// clear, dictionary and undefined transactions keep the input open
	a_dict_fast: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc && cmd != CMD_TEXT |=> in_ready)
		else $error("input closed after a non-text transaction");

	// a new result only comes from the finish step, when input is closed
	a_out_origin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(!in_ready) && $past(!last || !in_valid || !in_ready))
		else $error("result appeared outside a text finish");

endmodule

bind word_break_checker_top wbc_checker u_wbc_checker (.*);

### test/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for word_break_checker_top. A short directed sequence
// covers empty store, extreme bytes, clear, undefined commands and words
// added mid-text. Random phases then load small dictionaries (with overlong
// words and full-store bursts), stream texts built mostly from the loaded
// words, and check every verdict against a cycle-free model of the block.
// Both handshake sides insert random idle cycles.
// ----------------------------------------------------------------------------
module testbench;
	import wbc_pkg::*;

	localparam logic [1:0] CMD_UNDEF    = 2'd3;
	localparam int         RANDOM_ITEMS = 1650;
	localparam int         DIRECTED_N   = 23;
	localparam int         CYCLE_LIMIT  = 1000000;
	localparam int         DRAIN_CYCLES = 100;
	localparam int         VOCAB_MAX    = 80;
	localparam int         VOCAB_CHARS  = 40;

	typedef struct packed {
		logic brk;
		logic err;
	} verdict_t;

	typedef struct packed {
		logic [1:0] op;
		logic [7:0] chr;
		logic       fin;
		logic       typed;
		logic       brk;
		logic       err;
	} stim_row_t;

	logic       clk;
	logic       arst_n;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] cmd;
	logic [7:0] ch;
	logic       last;
	logic       out_valid;
	logic       out_ready;
	logic       breakable;
	logic       dict_error;

	word_break_checker_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.cmd       (cmd),
		.ch        (ch),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.breakable (breakable),
		.dict_error(dict_error)
	);

	always begin
		clk = 1'b0;
		#1;
		clk = 1'b1;
		#1;
	end

	// model of the word store, text window and prefix bits
	logic [7:0]              store_chars [DICT_WORDS][MAX_WORD_LEN];
	int                      store_len [DICT_WORDS];
	int                      n_words;
	int                      load_len;
	bit                      load_over;
	bit                      err_flag;
	logic [7:0]              window [MAX_WORD_LEN];
	logic [MAX_WORD_LEN:0]   history;

	verdict_t verdict_q[$];
	int       mismatches;
	int       items_sent;
	int       cycle_count;
	bit       calm_in;
	bit       calm_out;

	// stimulus vocabulary: words sent to the store in the current phase
	logic [7:0] vocab_chars [VOCAB_MAX][VOCAB_CHARS];
	int         vocab_len [VOCAB_MAX];
	int         vocab_n;
	bit         wide;
	int         alpha;
	int         base;

	stim_row_t directed_rows [DIRECTED_N] = '{
		'{CMD_TEXT,  8'h61, 1'b1, 1'b1, 1'b0, 1'b0},
		'{CMD_UNDEF, 8'h5a, 1'b1, 1'b0, 1'b0, 1'b0},
		'{CMD_DICT,  8'h61, 1'b0, 1'b0, 1'b0, 1'b0},
		'{CMD_DICT,  8'h62, 1'b1, 1'b0, 1'b0, 1'b0},
		'{CMD_DICT,  8'hff, 1'b1, 1'b0, 1'b0, 1'b0},
		'{CMD_DICT,  8'h00, 1'b1, 1'b0, 1'b0, 1'b0},
		'{CMD_TEXT,  8'h61, 1'b0, 1'b0, 1'b0, 1'b0},
		'{CMD_TEXT,  8'h62, 1'b0, 1'b0, 1'b0, 1'b0},
		'{CMD_TEXT,  8'hff, 1'b0, 1'b0, 1'b0, 1'b0},
		'{CMD_TEXT,  8'h00, 1'b1, 1'b1, 1'b1, 1'b0},
		'{CMD_TEXT,  8'h62, 1'b1, 1'b1, 1'b0, 1'b0},
		'{CMD_TEXT,  8'h61, 1'b0, 1'b0, 1'b0, 1'b0},
		'{CMD_TEXT,  8'h61, 1'b1, 1'b1, 1'b0, 1'b0},
		'{CMD_CLEAR, 8'h00, 1'b0, 1'b0, 1'b0, 1'b0},
		'{CMD_TEXT,  8'hff, 1'b1, 1'b1, 1'b0, 1'b0},
		'{CMD_DICT,  8'h78, 1'b1, 1'b0, 1'b0, 1'b0},
		'{CMD_TEXT,  8'h78, 1'b0, 1'b0, 1'b0, 1'b0},
		// word committed while a text is open
		'{CMD_DICT,  8'h79, 1'b1, 1'b0, 1'b0, 1'b0},
		'{CMD_TEXT,  8'h79, 1'b1, 1'b1, 1'b1, 1'b0},
		'{CMD_UNDEF, 8'hff, 1'b0, 1'b0, 1'b0, 1'b0},
		'{CMD_TEXT,  8'h78, 1'b1, 1'b1, 1'b1, 1'b0},
		'{CMD_CLEAR, 8'hff, 1'b1, 1'b0, 1'b0, 1'b0},
		'{CMD_TEXT,  8'h79, 1'b1, 1'b1, 1'b0, 1'b0}
	};

	function automatic void word_break_step(input logic [1:0] op, input logic [7:0] chr,
			input logic fin, output bit has_verdict, output verdict_t v);
		int w;
		int j;
		int wl;
		bit hit;
		bit same;
		has_verdict = 1'b0;
		v = '0;
		case (op)
			CMD_CLEAR: begin
				n_words = 0;
				load_len = 0;
				load_over = 1'b0;
				err_flag = 1'b0;
			end
			CMD_DICT: begin
				if (n_words < DICT_WORDS) begin
					if (load_len < MAX_WORD_LEN) begin
						store_chars[n_words][load_len] = chr;
						load_len++;
					end else begin
						load_over = 1'b1;
					end
				end
				if (fin) begin
					if (n_words >= DICT_WORDS || load_over) begin
						err_flag = 1'b1;
					end else begin
						store_len[n_words] = load_len;
						n_words++;
					end
					load_len = 0;
					load_over = 1'b0;
				end
			end
			CMD_TEXT: begin
				for (j = MAX_WORD_LEN - 1; j > 0; j--)
					window[j] = window[j-1];
				window[0] = chr;
				hit = 1'b0;
				for (w = 0; w < n_words && !hit; w++) begin
					wl = store_len[w];
					if (wl > 0 && wl <= MAX_WORD_LEN && history[wl-1]) begin
						same = 1'b1;
						for (j = 0; j < wl; j++)
							if (store_chars[w][j] != window[wl-1-j])
								same = 1'b0;
						hit = same;
					end
				end
				history = {history[MAX_WORD_LEN-1:0], hit};
				if (fin) begin
					has_verdict = 1'b1;
					v.brk = hit;
					v.err = err_flag;
					foreach (window[k])
						window[k] = '0;
					history = (MAX_WORD_LEN+1)'(1);
				end
			end
			default: ;
		endcase
	endfunction

	task automatic send(input logic [1:0] op, input logic [7:0] chr, input logic fin,
			input bit typed = 1'b0, input verdict_t typed_v = '0);
		int gap;
		bit has_verdict;
		verdict_t v;
		gap = calm_in ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		cmd <= op;
		ch <= chr;
		last <= fin;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		word_break_step(op, chr, fin, has_verdict, v);
		if (has_verdict)
			verdict_q.push_back(typed ? typed_v : v);
		if (op != CMD_UNDEF)
			items_sent++;
	endtask

	function automatic logic [7:0] pick_char();
		if (wide)
			return 8'($urandom_range(0, 255));
		return 8'(base + $urandom_range(0, alpha - 1));
	endfunction

	function automatic int word_length();
		int r;
		r = $urandom_range(0, 19);
		if (r == 0)
			return MAX_WORD_LEN;
		if (r == 1)
			return $urandom_range(MAX_WORD_LEN + 1, VOCAB_CHARS - 4);
		if (r <= 4)
			return $urandom_range(5, 12);
		return $urandom_range(1, 4);
	endfunction

	task automatic load_word(input int n);
		int i;
		logic [7:0] c;
		for (i = 0; i < n; i++) begin
			c = pick_char();
			if (vocab_n < VOCAB_MAX)
				vocab_chars[vocab_n][i] = c;
			send(CMD_DICT, c, i == n - 1);
		end
		if (vocab_n < VOCAB_MAX) begin
			vocab_len[vocab_n] = n;
			vocab_n++;
		end
	endtask

	task automatic send_text();
		logic [7:0] line_q[$];
		int parts;
		int w;
		int i;
		if (vocab_n > 0 && $urandom_range(0, 3) != 0) begin
			parts = $urandom_range(1, 5);
			repeat (parts) begin
				w = $urandom_range(0, vocab_n - 1);
				for (i = 0; i < vocab_len[w]; i++)
					line_q.push_back(vocab_chars[w][i]);
			end
			// near miss: one character spoiled
			if ($urandom_range(0, 3) == 0)
				line_q[$urandom_range(0, line_q.size() - 1)] = pick_char();
		end else begin
			repeat ($urandom_range(1, 8))
				line_q.push_back(pick_char());
		end
		for (i = 0; i < line_q.size(); i++) begin
			if ($urandom_range(0, 39) == 0)
				send(CMD_UNDEF, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
			if ($urandom_range(0, 49) == 0)
				load_word($urandom_range(1, 3));
			send(CMD_TEXT, line_q[i], i == line_q.size() - 1);
		end
	endtask

	// result side: random ready gaps, every transaction checked in order
	initial begin
		int gap;
		verdict_t want;
		calm_out = 1'b0;
		forever begin
			if ($urandom_range(0, 15) == 0)
				calm_out = !calm_out;
			gap = calm_out ? 0 : $urandom_range(0, 4);
			if (gap > 0) begin
				out_ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			out_ready <= 1'b1;
			@(posedge clk);
			while (!(out_valid && arst_n))
				@(posedge clk);
			if (verdict_q.size() == 0) begin
				mismatches++;
				if (mismatches <= 20)
					$display("%0t: unexpected result breakable %0b dict_error %0b",
						$time, breakable, dict_error);
			end else begin
				want = verdict_q.pop_front();
				if (breakable !== want.brk) begin
					mismatches++;
					if (mismatches <= 20)
						$display("%0t: breakable expected %0b actual %0b",
							$time, want.brk, breakable);
				end
				if (dict_error !== want.err) begin
					mismatches++;
					if (mismatches <= 20)
						$display("%0t: dict_error expected %0b actual %0b",
							$time, want.err, dict_error);
				end
			end
		end
	end

	always @(posedge clk)
		cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		int i;
		stim_row_t row;
		cycle_count = 0;
		mismatches = 0;
		items_sent = 0;
		vocab_n = 0;
		calm_in = 1'b0;
		wide = 1'b0;
		alpha = 2;
		base = 8'h61;
		n_words = 0;
		load_len = 0;
		load_over = 1'b0;
		err_flag = 1'b0;
		foreach (window[k])
			window[k] = '0;
		history = (MAX_WORD_LEN+1)'(1);
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		cmd <= CMD_CLEAR;
		ch <= '0;
		last <= 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIRECTED_N; i++) begin
			row = directed_rows[i];
			send(row.op, row.chr, row.fin, row.typed, '{brk: row.brk, err: row.err});
		end

		while (items_sent < DIRECTED_N + RANDOM_ITEMS) begin
			calm_in = ($urandom_range(0, 3) == 0);
			wide = ($urandom_range(0, 5) == 0);
			alpha = $urandom_range(2, 4);
			base = $urandom_range(0, 252);
			if ($urandom_range(0, 14) == 0) begin
				// overfill the store: the words past the last slot are dropped
				send(CMD_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
				vocab_n = 0;
				repeat (DICT_WORDS + $urandom_range(1, 3))
					load_word($urandom_range(1, 2));
			end else begin
				if ($urandom_range(0, 1) == 0) begin
					send(CMD_CLEAR, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
					vocab_n = 0;
				end
				repeat ($urandom_range(1, 6))
					load_word(word_length());
			end
			repeat ($urandom_range(2, 6))
				send_text();
		end
		in_valid <= 1'b0;

		while (verdict_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatches == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

### files.f
hw/rtl/wbc_pkg.sv
hw/rtl/wbc_cell.sv
hw/rtl/wbc_word_store.sv
hw/rtl/word_break_checker_top.sv
hw/rtl/wbc_checker.sv
test/testbench.sv
